FILE: rtl/pose_dead_reckoning_integrator_macros.svh
// ----------------------------------------------------------------------------
// Pose integrator assertion macros
// Shared same-cycle and next-cycle implication property forms for checkers.
// ----------------------------------------------------------------------------
`ifndef POSE_DEAD_RECKONING_INTEGRATOR_MACROS_SVH
`define POSE_DEAD_RECKONING_INTEGRATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define PDR_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst is high
`define PDR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/pdr_pkg.sv
// ----------------------------------------------------------------------------
// Pose integrator package
// Fixed-point formats, command codes, arctangent table and saturation helpers.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int VEC_W        = 34;
  localparam int PROD_W       = 64;
  localparam int SCALE_W      = PROD_W + 1 - FRAC_BITS;
  localparam int TRIG_SHIFT   = 30;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [PROD_W:0] HALF_FRAC = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W:0] HALF_TRIG = (PROD_W + 1)'(1) << (TRIG_SHIFT - 1);

  typedef enum logic [2:0] {
    CMD_FORWARD    = 3'd0,
    CMD_MOVE       = 3'd1,
    CMD_ROTATE     = 3'd2,
    CMD_ACCEL      = 3'd3,
    CMD_TURN_LEFT  = 3'd4,
    CMD_TURN_RIGHT = 3'd5,
    CMD_RSVD6      = 3'd6,
    CMD_RSVD7      = 3'd7
  } cmd_t;

  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [29:0] r;
    unique case (idx)
      4'd0:  r = 30'd536870912;
      4'd1:  r = 30'd316933406;
      4'd2:  r = 30'd167458907;
      4'd3:  r = 30'd85004756;
      4'd4:  r = 30'd42667331;
      4'd5:  r = 30'd21354465;
      4'd6:  r = 30'd10679838;
      4'd7:  r = 30'd5340245;
      4'd8:  r = 30'd2670163;
      4'd9:  r = 30'd1335087;
      4'd10: r = 30'd667544;
      4'd11: r = 30'd333772;
      4'd12: r = 30'd166886;
      4'd13: r = 30'd83443;
      4'd14: r = 30'd41722;
      4'd15: r = 30'd20861;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] heading16(input logic [ANGLE_BITS-1:0] h);
    logic [31:0] t;
    t = 32'(h) << (32 - ANGLE_BITS);
    return t[31:16];
  endfunction

endpackage

FILE: rtl/pdr_cordic.sv
// ----------------------------------------------------------------------------
// Pose integrator CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin
// of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
module pdr_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pdr_pkg::ANGLE_BITS-1:0] angle,
  output logic                           done,
  output logic signed [31:0]             cos_out,
  output logic signed [31:0]             sin_out
);
  import pdr_pkg::*;

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t                   state;
  logic [STEP_W-1:0]         step;
  logic signed [VEC_W-1:0]   vx;
  logic signed [VEC_W-1:0]   vy;
  logic signed [31:0]        z;
  logic [31:0]               turn;
  logic                      fold;
  logic signed [VEC_W-1:0]   sx;
  logic signed [VEC_W-1:0]   sy;
  logic signed [31:0]        at;

  assign turn = 32'(angle) << (32 - ANGLE_BITS);
  // second and third quadrant: start from the negated vector
  assign fold = turn[31] ^ turn[30];
  assign sx   = vx >>> step;
  assign sy   = vy >>> step;
  assign at   = 32'(atan_turn(step));

  assign cos_out = vx[31:0];
  assign sin_out = vy[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            vx    <= fold ? -CORDIC_GAIN : CORDIC_GAIN;
            vy    <= '0;
            z     <= $signed(turn ^ {fold, 31'b0});
            step  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z[31]) begin
            vx <= vx - sy;
            vy <= vy + sx;
            z  <= z - at;
          end else begin
            vx <= vx + sy;
            vy <= vy - sx;
            z  <= z + at;
          end
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= C_IDLE;
            done  <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/pose_dead_reckoning_integrator.sv
// ----------------------------------------------------------------------------
// Pose dead-reckoning integrator
// Keeps a planar pose and a speed; applies one motion command per beat and
// returns the updated pose. Steps along the heading use a shared CORDIC and
// one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  cmd      cmd_valid / cmd_stall   command, operand
//  pose     pose_valid / pose_stall pos_x, pos_y, heading, velocity
//
//  Forward does one CORDIC run and the x and y updates, move first scales
//  the operand by the speed, turns do two CORDIC runs of 16 micro-rotations
//  each; rotate, accelerate and reserved codes go straight to the result.
//  One command is in work at a time; cmd_stall is high until its result is
//  loaded into the output register. Reset clears the pose, speed and handshake.
//  A stalled result holds; the next command is taken while it waits.
// ----------------------------------------------------------------------------
module pose_dead_reckoning_integrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] operand,
  output logic               pose_valid,
  input  logic               pose_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic signed [31:0] velocity
);
  import pdr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_T, S_SCALE_T, S_SAT_T, S_ROT, S_CORDIC,
    S_MUL_X, S_SCALE_X, S_ADD_X, S_MUL_Y, S_SCALE_Y, S_ADD_Y, S_DONE
  } state_t;

  state_t                      state;
  cmd_t                        cmd_r;
  logic                        leg2;
  logic signed [31:0]          span;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SCALE_W-1:0]   scaled;
  logic signed [31:0]          x_pos;
  logic signed [31:0]          y_pos;
  logic [ANGLE_BITS-1:0]       head;
  logic signed [31:0]          vel;

  logic                        cordic_start;
  logic                        cordic_done;
  logic signed [31:0]          cos_v;
  logic signed [31:0]          sin_v;

  logic signed [31:0]          mul_a;
  logic signed [31:0]          mul_b;
  logic signed [PROD_W-1:0]    mul_out;
  logic signed [PROD_W:0]      rnd_sum;
  logic signed [PROD_W:0]      shifted;
  logic signed [31:0]          acc_base;
  logic signed [63:0]          acc_sum;
  logic signed [31:0]          acc_sat;

  pdr_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (head),
    .done    (cordic_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  assign cordic_start = (state == S_ROT);
  assign cmd_stall    = (state != S_IDLE);

  always_comb begin
    priority case (state)
      S_MUL_T: begin
        mul_a = span;
        mul_b = vel;
      end
      S_MUL_Y: begin
        mul_a = sin_v;
        mul_b = span;
      end
      default: begin
        mul_a = cos_v;
        mul_b = span;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_comb begin
    if (state == S_SCALE_T) begin
      rnd_sum = (PROD_W + 1)'(prod) + HALF_FRAC;
      shifted = rnd_sum >>> FRAC_BITS;
    end else begin
      rnd_sum = (PROD_W + 1)'(prod) + HALF_TRIG;
      shifted = rnd_sum >>> TRIG_SHIFT;
    end
  end

  always_comb begin
    priority case (state)
      S_ADD_X: acc_base = x_pos;
      S_ADD_Y: acc_base = y_pos;
      default: acc_base = '0;
    endcase
  end

  assign acc_sum = 64'(acc_base) + 64'(scaled);
  assign acc_sat = sat32(acc_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pose_valid <= 1'b0;
      leg2       <= 1'b0;
      x_pos      <= '0;
      y_pos      <= '0;
      head       <= '0;
      vel        <= '0;
    end else begin
      if (pose_valid && !pose_stall && state != S_DONE) begin
        pose_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd_t'(command);
            span  <= operand;
            leg2  <= 1'b0;
            unique case (cmd_t'(command))
              CMD_FORWARD, CMD_TURN_LEFT, CMD_TURN_RIGHT: state <= S_ROT;
              CMD_MOVE: state <= S_MUL_T;
              CMD_ROTATE: begin
                head  <= head + operand[ANGLE_BITS-1:0];
                state <= S_DONE;
              end
              CMD_ACCEL: begin
                vel   <= sat32(64'(vel) + 64'(operand));
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MUL_T: begin
          prod  <= mul_out;
          state <= S_SCALE_T;
        end
        S_SCALE_T: begin
          scaled <= shifted[SCALE_W-1:0];
          state  <= S_SAT_T;
        end
        S_SAT_T: begin
          span  <= acc_sat;
          state <= S_ROT;
        end
        S_ROT: state <= S_CORDIC;
        S_CORDIC: begin
          if (cordic_done) begin
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          prod  <= mul_out;
          state <= S_SCALE_X;
        end
        S_SCALE_X: begin
          scaled <= shifted[SCALE_W-1:0];
          state  <= S_ADD_X;
        end
        S_ADD_X: begin
          x_pos <= acc_sat;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          prod  <= mul_out;
          state <= S_SCALE_Y;
        end
        S_SCALE_Y: begin
          scaled <= shifted[SCALE_W-1:0];
          state  <= S_ADD_Y;
        end
        S_ADD_Y: begin
          y_pos <= acc_sat;
          if (!leg2 && (cmd_r == CMD_TURN_LEFT || cmd_r == CMD_TURN_RIGHT)) begin
            // quarter turn between the two legs
            head  <= (cmd_r == CMD_TURN_LEFT) ? head - QUARTER_TURN : head + QUARTER_TURN;
            leg2  <= 1'b1;
            state <= S_ROT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!pose_valid || !pose_stall) begin
            pose_valid <= 1'b1;
            pos_x      <= x_pos;
            pos_y      <= y_pos;
            heading    <= heading16(head);
            velocity   <= vel;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/pdr_checker.sv
// ----------------------------------------------------------------------------
// Pose integrator checker
// Port-level properties of the command and pose channels, bound to the top.
// ----------------------------------------------------------------------------
`include "pose_dead_reckoning_integrator_macros.svh"

module pdr_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               pose_valid,
  input logic               pose_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic [15:0]        heading,
  input logic signed [31:0] velocity
);

  `PDR_ASSERT_NEXT(a_busy_after_beat, cmd_valid && !cmd_stall, cmd_stall, "command beat not followed by busy")

  `PDR_ASSERT_NEXT(a_pose_hold, pose_valid && pose_stall, pose_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading) && $stable(velocity), "stalled pose beat changed")

  `PDR_ASSERT_NOW(a_result_from_work, $rose(pose_valid), $past(cmd_stall), "pose beat without command in work")

  `PDR_ASSERT_NOW(a_ready_with_result, $fell(cmd_stall) && !$past(rst), pose_valid, "ready again without a pose beat")

endmodule

bind pose_dead_reckoning_integrator pdr_checker u_pdr_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Pose dead-reckoning integrator testbench
// Sends forward, move, rotate, accelerate, turn and reserved command beats,
// with random gaps on the command side and random stalls on the pose side.
// A bit-exact pose tracker (CORDIC, saturation, heading wrap) predicts every
// pose beat, and each one is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pdr_pkg::*;

class pose_tracker;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
    logic signed [31:0] speed;
  } pose_t;

  localparam longint TRIG_GAIN = 64'sd652032874;

  logic signed [31:0]    x_pos;
  logic signed [31:0]    y_pos;
  logic [ANGLE_BITS-1:0] hdg;
  logic signed [31:0]    speed;
  longint                atan_tbl [16];
  pose_t                 expected_poses [$];
  int                    errors;
  int                    checked;
  int                    clamps;
  int                    cmd_seen [8];

  function new();
    atan_tbl = '{536870912, 316933406, 167458907, 85004756,
                 42667331, 21354465, 10679838, 5340245,
                 2670163, 1335087, 667544, 333772,
                 166886, 83443, 41722, 20861};
    x_pos = '0;
    y_pos = '0;
    hdg = '0;
    speed = '0;
    errors = 0;
    checked = 0;
    clamps = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
  endfunction

  function logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      clamps++;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clamps++;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // cos and sin of the heading in Q2.30
  function void trig(input logic [ANGLE_BITS-1:0] h, output longint c, output longint s);
    logic [31:0] turn;
    longint vx, vy, z, sx, sy;
    turn = 32'(h) << (32 - ANGLE_BITS);
    vx = TRIG_GAIN;
    vy = 0;
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      vx = -TRIG_GAIN;
      turn = turn - 32'h8000_0000;
    end
    z = longint'(signed'(turn));
    for (int i = 0; i < 16; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (z >= 0) begin
        vx = vx - sy;
        vy = vy + sx;
        z = z - atan_tbl[i];
      end else begin
        vx = vx + sy;
        vy = vy - sx;
        z = z + atan_tbl[i];
      end
    end
    c = vx;
    s = vy;
  endfunction

  function void advance(longint d);
    longint c, s;
    trig(hdg, c, s);
    x_pos = clamp32(longint'(x_pos) + ((c * d + (64'sd1 <<< 29)) >>> 30));
    y_pos = clamp32(longint'(y_pos) + ((s * d + (64'sd1 <<< 29)) >>> 30));
  endfunction

  function void apply_command(logic [2:0] c, logic signed [31:0] v);
    longint d, p;
    pose_t e;
    d = longint'(v);
    cmd_seen[c]++;
    case (c)
      CMD_FORWARD: advance(d);
      CMD_MOVE: begin
        p = (d * longint'(speed) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        advance(longint'(clamp32(p)));
      end
      CMD_ROTATE: hdg = hdg + v[ANGLE_BITS-1:0];
      CMD_ACCEL: speed = clamp32(longint'(speed) + d);
      CMD_TURN_LEFT: begin
        advance(d);
        hdg = hdg - QUARTER_TURN;
        advance(d);
      end
      CMD_TURN_RIGHT: begin
        advance(d);
        hdg = hdg + QUARTER_TURN;
        advance(d);
      end
      default: ;
    endcase
    e.x = x_pos;
    e.y = y_pos;
    e.hdg = 16'((32'(hdg) << (32 - ANGLE_BITS)) >> 16);
    e.speed = speed;
    expected_poses.push_back(e);
  endfunction

  task report_mismatch(string what, longint got, longint want);
    if (errors < 40) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  task check_pose(logic signed [31:0] x, logic signed [31:0] y, logic [15:0] h,
                  logic signed [31:0] v);
    pose_t e;
    if (expected_poses.size() == 0) begin
      report_mismatch("pose beat with nothing pending", 0, 0);
      return;
    end
    e = expected_poses.pop_front();
    checked++;
    if (x !== e.x) report_mismatch("pos_x", x, e.x);
    if (y !== e.y) report_mismatch("pos_y", y, e.y);
    if (h !== e.hdg) report_mismatch("heading", h, e.hdg);
    if (v !== e.speed) report_mismatch("velocity", v, e.speed);
  endtask

  function int pending();
    return expected_poses.size();
  endfunction
endclass

module testbench;
  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT  = 1_500_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [2:0]         command = '0;
  logic signed [31:0] operand = '0;
  logic               pose_valid;
  logic               pose_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [31:0] velocity;

  logic               no_gaps = 1'b0;
  int                 stall_hold = 0;
  int                 cycles = 0;
  pose_tracker        tracker = new();

  pose_dead_reckoning_integrator dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .operand    (operand),
    .pose_valid (pose_valid),
    .pose_stall (pose_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading    (heading),
    .velocity   (velocity)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pose_dead_reckoning_integrator: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pose_valid && !pose_stall) begin
      tracker.check_pose(pos_x, pos_y, heading, velocity);
    end
  end

  // hold or release the pose side in runs of random length
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      pose_stall = !no_gaps && ($urandom_range(0, 2) == 0);
      stall_hold = idle_len() - 1;
    end
  end

  task automatic send_beat(input logic [2:0] c, input logic signed [31:0] v);
    int gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid = 1'b1;
    command = c;
    operand = v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    tracker.apply_command(c, v);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_operand(logic [2:0] c);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh00000000;
        3: return -32'sd1;
        default: return 32'sh00000001;
      endcase
    end
    if (c == CMD_ROTATE) return $urandom();
    if (c == CMD_MOVE) return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
  endfunction

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CMD_FORWARD;
    if (r < 45) return CMD_MOVE;
    if (r < 60) return CMD_ROTATE;
    if (r < 73) return CMD_ACCEL;
    if (r < 84) return CMD_TURN_LEFT;
    if (r < 95) return CMD_TURN_RIGHT;
    if (r < 98) return CMD_RSVD6;
    return CMD_RSVD7;
  endfunction

  task automatic run_directed();
    send_beat(CMD_FORWARD, 32'sh0000_0000);
    send_beat(CMD_FORWARD, 32'sh0001_0000);
    send_beat(CMD_ROTATE, 32'sh0000_2000);
    send_beat(CMD_FORWARD, 32'sh7fff_ffff);
    send_beat(CMD_FORWARD, 32'sh8000_0000);
    send_beat(CMD_ROTATE, 32'shffff_6000);
    send_beat(CMD_FORWARD, 32'sh0003_0000);
    send_beat(CMD_ROTATE, 32'sh0000_3fff);
    send_beat(CMD_FORWARD, 32'sh0001_0000);
    send_beat(CMD_ROTATE, 32'sh0000_0001);
    send_beat(CMD_FORWARD, -32'sh0001_0000);
    send_beat(CMD_ACCEL, 32'sh7fff_ffff);
    send_beat(CMD_ACCEL, 32'sh7fff_ffff);
    send_beat(CMD_MOVE, 32'sh7fff_ffff);
    send_beat(CMD_ACCEL, 32'sh8000_0000);
    send_beat(CMD_ACCEL, 32'sh8000_0000);
    send_beat(CMD_MOVE, 32'sh0000_8000);
    send_beat(CMD_MOVE, 32'sh8000_0000);
    send_beat(CMD_TURN_LEFT, 32'sh0002_0000);
    send_beat(CMD_TURN_RIGHT, 32'sh0002_0000);
    send_beat(CMD_TURN_LEFT, 32'sh7fff_ffff);
    send_beat(CMD_TURN_RIGHT, 32'sh8000_0000);
    send_beat(CMD_RSVD6, 32'sh1234_5678);
    send_beat(CMD_RSVD7, -32'sd1);
    send_beat(CMD_ACCEL, 32'sh7fff_ffff);
    send_beat(CMD_ACCEL, 32'sh0001_8000);
    send_beat(CMD_ROTATE, 32'sh0000_ffff);
  endtask

  initial begin
    logic [2:0] c;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      no_gaps = ((n / 150) % 4 == 3);
      c = pick_command();
      send_beat(c, pick_operand(c));
    end
    cmd_valid = 1'b0;
    no_gaps = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d commands: %0d forward, %0d move, %0d rotate, %0d accel, %0d turns,",
             tracker.cmd_seen.sum(), tracker.cmd_seen[CMD_FORWARD],
             tracker.cmd_seen[CMD_MOVE], tracker.cmd_seen[CMD_ROTATE],
             tracker.cmd_seen[CMD_ACCEL],
             tracker.cmd_seen[CMD_TURN_LEFT] + tracker.cmd_seen[CMD_TURN_RIGHT]);
    $display("%0d reserved, %0d pose beats checked, %0d saturating updates, %0d field errors",
             tracker.cmd_seen[CMD_RSVD6] + tracker.cmd_seen[CMD_RSVD7],
             tracker.checked, tracker.clamps, tracker.errors);
    if (tracker.errors == 0) begin
      $display("pose_dead_reckoning_integrator: match");
    end else begin
      $display("pose_dead_reckoning_integrator: mismatch");
    end
    $finish;
  end
endmodule
